// File: hdl/pbf_pkg.sv
package pbf_pkg;

	// pipeline depths of the arithmetic units
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 32;
	localparam int MUL_STAGES = 2;

	// register indexes of the configuration port
	localparam logic [1:0] REG_HORIZON = 2'd0;
	localparam logic [1:0] REG_SPACING = 2'd1;
	localparam logic [1:0] REG_MODE    = 2'd2;

	// dimension modes, code 3 behaves as three-dimensional
	localparam logic [1:0] MODE_3D     = 2'd0;
	localparam logic [1:0] MODE_STRESS = 2'd1;
	localparam logic [1:0] MODE_STRAIN = 2'd2;

	// micromodulus constants c / (2 pi), q.30
	localparam logic [30:0] K_3D     = 31'd2050695827;
	localparam logic [30:0] K_STRESS = 31'd1538021870;
	localparam logic [30:0] K_STRAIN = 31'd1640556661;

endpackage

// File: hdl/pbf_mulq30.sv
module pbf_mulq30 (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);

	logic [63:0] p00_s1, p01_s1, p10_s1, p11_s1;
	logic [63:0] p_s2;
	logic [33:0] mid;
	logic [63:0] lo;
	logic [63:0] hi;

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
			p01_s1 <= 64'(a[31:0]) * 64'(b[63:32]);
			p10_s1 <= 64'(a[63:32]) * 64'(b[31:0]);
			p11_s1 <= 64'(a[63:32]) * 64'(b[63:32]);
		end
	end

	always_comb begin
		mid = 34'(p00_s1[63:32]) + 34'(p01_s1[31:0]) + 34'(p10_s1[31:0]);
		lo  = {mid[31:0], p00_s1[31:0]};
		hi  = p11_s1 + 64'(p01_s1[63:32]) + 64'(p10_s1[63:32]) + 64'(mid[33:32]);
	end

	// saturate once the shifted product leaves 64 bits
	always_ff @(posedge clk) begin
		if (en) begin
			if (hi[63:30] != '0) begin
				p_s2 <= '1;
			end else begin
				p_s2 <= {hi[29:0], lo[63:30]};
			end
		end
	end

	assign p = p_s2;

endmodule

// File: hdl/pbf_sqrt.sv
module pbf_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] x,
	output logic [31:0] root
);

	logic [33:0] rem_s  [pbf_pkg::SQRT_STEPS];
	logic [31:0] root_s [pbf_pkg::SQRT_STEPS];
	logic [63:0] xs_s   [pbf_pkg::SQRT_STEPS];
	logic [33:0] rem_n  [pbf_pkg::SQRT_STEPS];
	logic [31:0] root_n [pbf_pkg::SQRT_STEPS];
	logic [63:0] xs_n   [pbf_pkg::SQRT_STEPS];

	// one root bit per stage, two radicand bits shifted in each time
	always_comb begin
		logic [35:0] cur;
		logic [35:0] trial;
		logic [33:0] prem;
		logic [31:0] proot;
		logic [63:0] px;
		for (int g = 0; g < pbf_pkg::SQRT_STEPS; g++) begin
			if (g == 0) begin
				prem  = '0;
				proot = '0;
				px    = x;
			end else begin
				prem  = rem_s[g-1];
				proot = root_s[g-1];
				px    = xs_s[g-1];
			end
			cur   = {prem, px[63:62]};
			trial = {2'b00, proot, 2'b01};
			if (cur >= trial) begin
				rem_n[g]  = 34'(cur - trial);
				root_n[g] = {proot[30:0], 1'b1};
			end else begin
				rem_n[g]  = cur[33:0];
				root_n[g] = {proot[30:0], 1'b0};
			end
			xs_n[g] = {px[61:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < pbf_pkg::SQRT_STEPS; g++) begin
				rem_s[g]  <= rem_n[g];
				root_s[g] <= root_n[g];
				xs_s[g]   <= xs_n[g];
			end
		end
	end

	assign root = root_s[pbf_pkg::SQRT_STEPS-1];

endmodule

// File: hdl/pbf_div.sv
module pbf_div (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic [31:0] quo
);

	// restoring division, quotient below 2^32 by construction
	logic [31:0] rem_s [pbf_pkg::DIV_STEPS];
	logic [31:0] quo_s [pbf_pkg::DIV_STEPS];
	logic [31:0] lo_s  [pbf_pkg::DIV_STEPS];
	logic [31:0] den_s [pbf_pkg::DIV_STEPS];
	logic [31:0] rem_n [pbf_pkg::DIV_STEPS];
	logic [31:0] quo_n [pbf_pkg::DIV_STEPS];
	logic [31:0] lo_n  [pbf_pkg::DIV_STEPS];
	logic [31:0] den_n [pbf_pkg::DIV_STEPS];

	always_comb begin
		logic [32:0] cur;
		logic [31:0] prem;
		logic [31:0] pquo;
		logic [31:0] plo;
		logic [31:0] pden;
		for (int g = 0; g < pbf_pkg::DIV_STEPS; g++) begin
			if (g == 0) begin
				prem = num[63:32];
				plo  = num[31:0];
				pquo = '0;
				pden = den;
			end else begin
				prem = rem_s[g-1];
				plo  = lo_s[g-1];
				pquo = quo_s[g-1];
				pden = den_s[g-1];
			end
			cur = {prem, plo[31]};
			if (cur >= {1'b0, pden}) begin
				rem_n[g] = 32'(cur - {1'b0, pden});
				quo_n[g] = {pquo[30:0], 1'b1};
			end else begin
				rem_n[g] = cur[31:0];
				quo_n[g] = {pquo[30:0], 1'b0};
			end
			lo_n[g]  = {plo[30:0], 1'b0};
			den_n[g] = pden;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < pbf_pkg::DIV_STEPS; g++) begin
				rem_s[g] <= rem_n[g];
				quo_s[g] <= quo_n[g];
				lo_s[g]  <= lo_n[g];
				den_s[g] <= den_n[g];
			end
		end
	end

	assign quo = quo_s[pbf_pkg::DIV_STEPS-1];

endmodule

// File: hdl/pbf_scale.sv
module pbf_scale (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] horizon,
	input  logic [30:0] spacing,
	input  logic [1:0]  mode,
	output logic        busy,
	output logic [63:0] gain
);

	localparam int R_BITS = 61;

	typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV, ST_MUL} state_t;

	state_t      state_q;
	logic [5:0]  cnt_q;
	logic [1:0]  step_q;
	logic [30:0] rem_q;
	logic [30:0] den_q;
	logic [60:0] num_q;
	logic [60:0] quo_q;
	logic [41:0] dxsq_q;
	logic [63:0] a_q, b_q;
	logic [63:0] gain_q;
	logic [63:0] prod;
	logic [31:0] cur;
	logic        ge;
	logic [60:0] quo_n;
	logic        planar;

	pbf_mulq30 u_mul (
		.clk (clk),
		.en  (1'b1),
		.a   (a_q),
		.b   (b_q),
		.p   (prod)
	);

	always_comb begin
		cur    = {rem_q, num_q[60]};
		ge     = cur >= {1'b0, den_q};
		quo_n  = {quo_q[59:0], ge};
		planar = (mode == pbf_pkg::MODE_STRESS) || (mode == pbf_pkg::MODE_STRAIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			step_q  <= '0;
			rem_q   <= '0;
			den_q   <= '0;
			num_q   <= '0;
			quo_q   <= '0;
			dxsq_q  <= '0;
			a_q     <= '0;
			b_q     <= '0;
			gain_q  <= '0;
		end else if (start) begin
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_LOAD: begin
					rem_q   <= '0;
					den_q   <= (horizon == '0) ? 31'd1 : horizon;
					num_q   <= {spacing, 30'b0};
					quo_q   <= '0;
					cnt_q   <= '0;
					step_q  <= '0;
					dxsq_q  <= 42'((62'(spacing) * 62'(spacing)) >> 20);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= ge ? 31'(cur - {1'b0, den_q}) : cur[30:0];
					quo_q <= quo_n;
					num_q <= {num_q[59:0], 1'b0};
					if (cnt_q == 6'(R_BITS - 1)) begin
						a_q     <= 64'(quo_n);
						b_q     <= 64'(quo_n);
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_MUL: begin
					if (cnt_q == 6'(pbf_pkg::MUL_STAGES)) begin
						cnt_q <= '0;
						case (step_q)
							2'd0: begin
								a_q <= prod;
								b_q <= planar ? 64'(quo_q) : prod;
							end
							2'd1: begin
								a_q <= prod;
								b_q <= planar ? 64'(spacing) : 64'(dxsq_q);
							end
							default: begin
								gain_q  <= prod;
								state_q <= ST_IDLE;
							end
						endcase
						step_q <= step_q + 2'd1;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign gain = gain_q;

endmodule

// File: hdl/peridynamic_bond_force.sv
// throughput: one bond per cycle while in_stall is low, set by the fully pipelined sqrt,
// divider and multiplier stages; the whole pipeline advances together, and an unaccepted
// output beat holds every stage
// reset: registers take their reset values, then the gain computation holds in_stall high
// every configuration write restarts that gain computation
module peridynamic_bond_force (
	input  logic               clk,
	input  logic               arst_n,
	// bond input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] ref_dx,
	input  logic signed [31:0] ref_dy,
	input  logic signed [31:0] ref_dz,
	input  logic signed [31:0] cur_dx,
	input  logic signed [31:0] cur_dy,
	input  logic signed [31:0] cur_dz,
	input  logic [31:0]        modulus_first,
	input  logic [31:0]        modulus_second,
	input  logic [31:0]        limit_first,
	input  logic [31:0]        limit_second,
	// force output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] force_x,
	output logic signed [63:0] force_y,
	output logic signed [63:0] force_z,
	output logic               bond_broken,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int CHAIN = 4 * pbf_pkg::MUL_STAGES;

	// sideband through the front end and the square roots
	typedef struct packed {
		logic [2:0][31:0] cmag;
		logic [2:0]       cneg;
		logic [32:0]      msum;
		logic [31:0]      crit;
	} side_a_t;

	// sideband through the dividers
	typedef struct packed {
		logic        l0z;
		logic        lnz;
		logic        pos;
		logic        big;
		logic        c1;
		logic        c2;
		logic [2:0]  cneg;
		logic [32:0] msum;
		logic [31:0] crit;
	} side_b_t;

	// sideband through the multiplier chain
	typedef struct packed {
		logic [30:0]      beta;
		logic [2:0][31:0] u;
		logic [2:0]       neg;
		logic             zero;
		logic             broken;
	} side_c_t;

	// configuration registers
	logic [30:0] horizon_q;
	logic [30:0] spacing_q;
	logic [1:0]  mode_q;
	logic        cfg_wr;
	logic        busy;
	logic [63:0] gain;

	// handshake
	logic adv;
	logic accept;

	// front end
	logic [2:0][31:0] rmag_s1;
	side_a_t          sda_s1;
	logic [2:0][63:0] rsq_s2, csq_s2;
	side_a_t          sda_s2;
	logic [63:0]      sum_ref_s3, sum_cur_s3;
	side_a_t          sda_s3;
	logic             v_s1, v_s2, v_s3;

	// square root section
	side_a_t     sa_s [pbf_pkg::SQRT_STEPS];
	logic        va_s [pbf_pkg::SQRT_STEPS];
	logic [31:0] l0, ln;

	// divider set-up
	logic [63:0]      snum_s4, bnum_s4;
	logic [2:0][63:0] unum_s4;
	logic [31:0]      l0_s4, ln_s4;
	side_b_t          sdb_s4;
	logic             v_s4;
	logic [63:0]      snum_n, bnum_n;
	logic [2:0][63:0] unum_n;
	side_b_t          sdb_n;

	// divider section
	side_b_t          sb_s [pbf_pkg::DIV_STEPS];
	logic             vb_s [pbf_pkg::DIV_STEPS];
	logic [31:0]      q_s, q_b;
	logic [2:0][31:0] q_u;

	// decision stage
	logic [63:0] fac0_s5;
	logic [31:0] smag_s5;
	side_c_t     sdc_s5;
	logic        v_s5;
	logic [63:0] fac0_n;
	side_c_t     sdc_n;
	logic [30:0] k_sel;

	// multiplier chain
	side_c_t          sc_s [CHAIN];
	logic             vc_s [CHAIN];
	logic [63:0]      p1, p2, p3;
	logic [2:0][63:0] p4;

	// output beat
	logic             out_valid_q;
	logic [2:0][63:0] force_q;
	logic             broken_q;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? 32'(-v) : v;
	endfunction

	function automatic logic [63:0] sat_force(input logic [63:0] f, input logic neg,
			input logic zero);
		logic [63:0] fm;
		if (zero || f == '0) begin
			return '0;
		end else if (neg) begin
			fm = (f > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : f;
			return 64'(64'd0 - fm);
		end else begin
			return f[63] ? 64'h7FFF_FFFF_FFFF_FFFF : f;
		end
	endfunction

	// configuration port, always ready
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horizon_q <= 31'd3145728;
			spacing_q <= 31'd1048576;
			mode_q    <= pbf_pkg::MODE_3D;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				pbf_pkg::REG_HORIZON: horizon_q <= cfg_data[30:0];
				pbf_pkg::REG_SPACING: spacing_q <= cfg_data[30:0];
				pbf_pkg::REG_MODE:    mode_q    <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// gain g from horizon, spacing and mode, recomputed after any write
	pbf_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cfg_wr),
		.horizon (horizon_q),
		.spacing (spacing_q),
		.mode    (mode_q),
		.busy    (busy),
		.gain    (gain)
	);

	// one enable moves every stage; a held output beat freezes the lot
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv || busy;
	assign accept   = in_valid && !in_stall;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < pbf_pkg::SQRT_STEPS; i++) va_s[i] <= 1'b0;
			for (int i = 0; i < pbf_pkg::DIV_STEPS; i++) vb_s[i] <= 1'b0;
			for (int i = 0; i < CHAIN; i++) vc_s[i] <= 1'b0;
		end else if (adv) begin
			v_s1    <= accept;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			va_s[0] <= v_s3;
			for (int i = 1; i < pbf_pkg::SQRT_STEPS; i++) va_s[i] <= va_s[i-1];
			v_s4    <= va_s[pbf_pkg::SQRT_STEPS-1];
			vb_s[0] <= v_s4;
			for (int i = 1; i < pbf_pkg::DIV_STEPS; i++) vb_s[i] <= vb_s[i-1];
			v_s5    <= vb_s[pbf_pkg::DIV_STEPS-1];
			vc_s[0] <= v_s5;
			for (int i = 1; i < CHAIN; i++) vc_s[i] <= vc_s[i-1];
			out_valid_q <= vc_s[CHAIN-1];
		end
	end

	// front end: magnitudes, squares, sums of squares
	always_ff @(posedge clk) begin
		if (adv) begin
			rmag_s1[0]     <= mag32(ref_dx);
			rmag_s1[1]     <= mag32(ref_dy);
			rmag_s1[2]     <= mag32(ref_dz);
			sda_s1.cmag[0] <= mag32(cur_dx);
			sda_s1.cmag[1] <= mag32(cur_dy);
			sda_s1.cmag[2] <= mag32(cur_dz);
			sda_s1.cneg    <= {cur_dz[31], cur_dy[31], cur_dx[31]};
			sda_s1.msum    <= 33'(modulus_first) + 33'(modulus_second);
			sda_s1.crit    <= 32'((33'(limit_first) + 33'(limit_second)) >> 1);

			for (int c = 0; c < 3; c++) begin
				rsq_s2[c] <= 64'(rmag_s1[c]) * 64'(rmag_s1[c]);
				csq_s2[c] <= 64'(sda_s1.cmag[c]) * 64'(sda_s1.cmag[c]);
			end
			sda_s2 <= sda_s1;

			// three squares of at most 2^62 each, no carry out of 64 bits
			sum_ref_s3 <= rsq_s2[0] + rsq_s2[1] + rsq_s2[2];
			sum_cur_s3 <= csq_s2[0] + csq_s2[1] + csq_s2[2];
			sda_s3     <= sda_s2;
		end
	end

	// reference and current lengths
	pbf_sqrt u_sqrt_ref (
		.clk  (clk),
		.en   (adv),
		.x    (sum_ref_s3),
		.root (l0)
	);

	pbf_sqrt u_sqrt_cur (
		.clk  (clk),
		.en   (adv),
		.x    (sum_cur_s3),
		.root (ln)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sa_s[0] <= sda_s3;
			for (int i = 1; i < pbf_pkg::SQRT_STEPS; i++) sa_s[i] <= sa_s[i-1];
		end
	end

	// divider set-up: stretch numerator, volume correction numerator, direction cosines
	always_comb begin
		side_a_t     sa;
		logic [31:0] d;
		logic [33:0] twol0;
		logic [33:0] twoh;
		logic [33:0] bn;
		sa    = sa_s[pbf_pkg::SQRT_STEPS-1];
		twol0 = {1'b0, l0, 1'b0};
		twoh  = {2'b00, horizon_q, 1'b0};

		sdb_n.pos  = ln >= l0;
		sdb_n.l0z  = (l0 == '0);
		sdb_n.lnz  = (ln == '0);
		d          = sdb_n.pos ? 32'(ln - l0) : 32'(l0 - ln);
		// stretch of 4 or more exceeds any critical stretch
		sdb_n.big  = {2'b00, d} >= {l0, 2'b00};
		// a shrinking bond rounds its stretch magnitude up
		snum_n     = sdb_n.pos ? {2'b00, d, 30'b0}
			: 64'({2'b00, d, 30'b0} + 64'(l0) - 64'd1);

		sdb_n.c1   = (twol0 + 34'(spacing_q)) <= twoh;
		sdb_n.c2   = twol0 <= (twoh + 34'(spacing_q));
		bn         = 34'(twoh + 34'(spacing_q) - twol0);
		bnum_n     = {3'b000, bn[31:0], 29'b0};

		for (int c = 0; c < 3; c++) begin
			unum_n[c] = {2'b00, sa.cmag[c], 30'b0};
		end
		sdb_n.cneg = sa.cneg;
		sdb_n.msum = sa.msum;
		sdb_n.crit = sa.crit;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			snum_s4 <= snum_n;
			bnum_s4 <= bnum_n;
			unum_s4 <= unum_n;
			l0_s4   <= l0;
			ln_s4   <= ln;
			sdb_s4  <= sdb_n;
		end
	end

	pbf_div u_div_s (
		.clk (clk),
		.en  (adv),
		.num (snum_s4),
		.den (l0_s4),
		.quo (q_s)
	);

	pbf_div u_div_b (
		.clk (clk),
		.en  (adv),
		.num (bnum_s4),
		.den ({1'b0, spacing_q}),
		.quo (q_b)
	);

	for (genvar c = 0; c < 3; c++) begin : g_dir
		pbf_div u_div_u (
			.clk (clk),
			.en  (adv),
			.num (unum_s4[c]),
			.den (ln_s4),
			.quo (q_u[c])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s[0] <= sdb_s4;
			for (int i = 1; i < pbf_pkg::DIV_STEPS; i++) sb_s[i] <= sb_s[i-1];
		end
	end

	// break decision, beta, micromodulus times modulus sum
	always_comb begin
		side_b_t sb;
		sb = sb_s[pbf_pkg::DIV_STEPS-1];
		case (mode_q)
			pbf_pkg::MODE_STRESS: k_sel = pbf_pkg::K_STRESS;
			pbf_pkg::MODE_STRAIN: k_sel = pbf_pkg::K_STRAIN;
			default:              k_sel = pbf_pkg::K_3D;
		endcase

		// a shrinking bond never breaks, its stretch is below zero
		sdc_n.broken = !sb.l0z && sb.pos && (sb.big || q_s >= sb.crit);
		sdc_n.zero   = sb.l0z || sb.lnz || sdc_n.broken;
		if (sb.c1) begin
			sdc_n.beta = 31'h4000_0000;
		end else if (sb.c2) begin
			sdc_n.beta = q_b[30:0];
		end else begin
			sdc_n.beta = '0;
		end
		for (int c = 0; c < 3; c++) begin
			sdc_n.u[c]   = q_u[c];
			sdc_n.neg[c] = !sb.pos ^ sb.cneg[c];
		end
		fac0_n = 64'(sb.msum) * 64'(k_sel);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fac0_s5 <= fac0_n;
			smag_s5 <= q_s;
			sdc_s5  <= sdc_n;
		end
	end

	// fac = msum k |s| beta g, then one product per axis
	pbf_mulq30 u_mul_s (
		.clk (clk),
		.en  (adv),
		.a   (fac0_s5),
		.b   (64'(smag_s5)),
		.p   (p1)
	);

	pbf_mulq30 u_mul_b (
		.clk (clk),
		.en  (adv),
		.a   (p1),
		.b   (64'(sc_s[pbf_pkg::MUL_STAGES-1].beta)),
		.p   (p2)
	);

	pbf_mulq30 u_mul_g (
		.clk (clk),
		.en  (adv),
		.a   (p2),
		.b   (gain),
		.p   (p3)
	);

	for (genvar c = 0; c < 3; c++) begin : g_axis
		pbf_mulq30 u_mul_u (
			.clk (clk),
			.en  (adv),
			.a   (p3),
			.b   (64'(sc_s[3*pbf_pkg::MUL_STAGES-1].u[c])),
			.p   (p4[c])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sc_s[0] <= sdc_s5;
			for (int i = 1; i < CHAIN; i++) sc_s[i] <= sc_s[i-1];
		end
	end

	// output register: sign, saturation, zero for broken or degenerate bonds
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				force_q[c] <= sat_force(p4[c], sc_s[CHAIN-1].neg[c], sc_s[CHAIN-1].zero);
			end
			broken_q <= sc_s[CHAIN-1].broken;
		end
	end

	assign out_valid   = out_valid_q;
	assign force_x     = force_q[0];
	assign force_y     = force_q[1];
	assign force_z     = force_q[2];
	assign bond_broken = broken_q;

	// a broken bond carries no force
	a_broken_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bond_broken |-> force_x == '0 && force_y == '0 && force_z == '0)
		else $error("broken bond with nonzero force");

	// a configuration write blocks bonds while the gain is recomputed
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> in_stall)
		else $error("bond accepted during gain recompute");

	// a stalled output beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(force_x) && $stable(force_y)
			&& $stable(force_z) && $stable(bond_broken))
		else $error("output beat changed while stalled");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	// one bond as it sits on the input ports
	typedef struct {
		logic signed [31:0] rx, ry, rz;
		logic signed [31:0] cx, cy, cz;
		logic [31:0]        mod_i, mod_j;
		logic [31:0]        lim_i, lim_j;
	} bond_t;

	// one force beat as it leaves the block
	typedef struct {
		logic signed [63:0] fx, fy, fz;
		logic               broken;
	} force_t;

	localparam logic [63:0] SAT = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int          STALL_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] ref_dx = '0, ref_dy = '0, ref_dz = '0;
	logic signed [31:0] cur_dx = '0, cur_dy = '0, cur_dz = '0;
	logic [31:0]        modulus_first = '0, modulus_second = '0;
	logic [31:0]        limit_first = '0, limit_second = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [63:0] force_x, force_y, force_z;
	logic               bond_broken;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	// our own copy of the registers, follows every accepted write
	logic [30:0] horizon_q = 31'd3145728;
	logic [30:0] spacing_q = 31'd1048576;
	logic [1:0]  mode_q = pbf_pkg::MODE_3D;

	bond_t  bonds_pending[$];
	force_t forces_due[$];
	int     errors = 0;
	int     quiet_cycles = 0;
	bit     steady = 1'b0;   // when set, neither side idles

	always #6 clk = ~clk;

	peridynamic_bond_force uut (.*);

	// ---------------------------------------------------------------- arithmetic

	// (a * b) >> 30 on the full product, saturating
	function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		if (p[127:94] != 0)
			return SAT;
		return p[93:30];
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] x);
		logic [63:0] res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > x)
			bt >>= 2;
		while (bt != 0) begin
			if (x >= res + bt) begin
				x -= res + bt;
				res = (res >> 1) + bt;
			end else
				res >>= 1;
			bt >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] mag32(logic signed [31:0] v);
		longint sv;
		sv = longint'(v);
		return sv < 0 ? -sv : sv;
	endfunction

	function automatic logic [63:0] length_of(logic signed [31:0] x, y, z);
		return root_floor(mag32(x) * mag32(x) + mag32(y) * mag32(y) + mag32(z) * mag32(z));
	endfunction

	// expected force beat for one bond under the current register copy
	function automatic force_t bond_force(bond_t b);
		force_t      f;
		logic [63:0] l0, ln, h, dx, crit, beta, r, r2, g, k, fac, smag, u, m;
		logic signed [31:0] c;
		longint      s;
		bit          neg;
		f = '{0, 0, 0, 1'b0};
		l0 = length_of(b.rx, b.ry, b.rz);
		ln = length_of(b.cx, b.cy, b.cz);
		h = horizon_q;
		dx = spacing_q;
		if (l0 == 0)
			return f;
		if (ln >= l0)
			s = longint'(((ln - l0) << 30) / l0);
		else
			s = -longint'((((l0 - ln) << 30) + l0 - 1) / l0);
		crit = (64'(b.lim_i) + 64'(b.lim_j)) >> 1;
		if (s >= longint'(crit)) begin
			f.broken = 1'b1;
			return f;
		end
		if (ln == 0 || dx == 0)
			return f;
		// volume correction, full inside the horizon, ramps down across one spacing
		if (2 * l0 + dx <= 2 * h)
			beta = 64'd1 << 30;
		else if (2 * l0 <= 2 * h + dx)
			beta = ((2 * h + dx - 2 * l0) << 29) / dx;
		else
			beta = 0;
		r = (dx << 30) / (h == 0 ? 64'd1 : h);
		r2 = mul_q30(r, r);
		if (mode_q == pbf_pkg::MODE_STRESS || mode_q == pbf_pkg::MODE_STRAIN) begin
			g = mul_q30(mul_q30(r2, r), dx);
			k = (mode_q == pbf_pkg::MODE_STRESS) ? 64'(pbf_pkg::K_STRESS)
				: 64'(pbf_pkg::K_STRAIN);
		end else begin
			g = mul_q30(mul_q30(r2, r2), (dx * dx) >> 20);
			k = 64'(pbf_pkg::K_3D);
		end
		smag = s < 0 ? 64'(-s) : 64'(s);
		fac = (64'(b.mod_i) + 64'(b.mod_j)) * k;
		fac = mul_q30(fac, smag);
		fac = mul_q30(fac, beta);
		fac = mul_q30(fac, g);
		for (int i = 0; i < 3; i++) begin
			c = (i == 0) ? b.cx : (i == 1) ? b.cy : b.cz;
			u = (mag32(c) << 30) / ln;
			m = mul_q30(fac, u);
			neg = (s < 0) != (c < 0);
			if (m != 0) begin
				if (neg) begin
					if (m > 64'h8000_0000_0000_0000)
						m = 64'h8000_0000_0000_0000;
					m = -m;
				end else if (m > 64'h7FFF_FFFF_FFFF_FFFF)
					m = 64'h7FFF_FFFF_FFFF_FFFF;
			end
			if (i == 0) f.fx = m;
			else if (i == 1) f.fy = m;
			else f.fz = m;
		end
		return f;
	endfunction

	// ---------------------------------------------------------------- stimulus makers

	function automatic bond_t bond_of(int rx, ry, rz, cx, cy, cz,
			logic [31:0] ei, ej, si, sj);
		bond_t b;
		b = '{rx, ry, rz, cx, cy, cz, ei, ej, si, sj};
		return b;
	endfunction

	// append one bond to the pending queue
	function automatic void add_bond(bond_t b);
		bonds_pending = {bonds_pending, b};
	endfunction

	// anything at all the ports allow
	function automatic bond_t noise_bond();
		return bond_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom);
	endfunction

	// a plausible bond: each axis within span of zero, small strain, limits near the strain
	function automatic bond_t lattice_bond(int span);
		int rx, ry, rz, kk;
		rx = $urandom_range(2 * span) - span;
		ry = $urandom_range(2 * span) - span;
		rz = $urandom_range(2 * span) - span;
		kk = int'($urandom_range(80)) - 40;
		return bond_of(rx, ry, rz,
			rx + ((rx * kk) >>> 10) + int'($urandom_range(64)) - 32,
			ry + ((ry * kk) >>> 10) + int'($urandom_range(64)) - 32,
			rz + ((rz * kk) >>> 10) + int'($urandom_range(64)) - 32,
			$urandom_range(200000), $urandom_range(200000),
			$urandom_range(32'h0400_0000), $urandom_range(32'h0400_0000));
	endfunction

	function automatic bond_t mixed_bond(int span);
		int pick;
		pick = $urandom_range(99);
		if (pick < 12)
			return noise_bond();
		if (pick < 20) begin
			// moduli and limits at full range on a sane geometry
			bond_t b;
			b = lattice_bond(span);
			b.mod_i = $urandom;
			b.mod_j = $urandom;
			b.lim_i = $urandom;
			b.lim_j = $urandom;
			return b;
		end
		return lattice_bond(span);
	endfunction

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin
		bond_t b;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && in_stall)) begin
			// beat taken, predict it from what sat on the ports
			if (in_valid)
				forces_due = {forces_due, bond_force(bond_of(ref_dx, ref_dy, ref_dz,
					cur_dx, cur_dy, cur_dz, modulus_first, modulus_second,
					limit_first, limit_second))};
			if (bonds_pending.size() > 0 && (steady || $urandom_range(99) >= 35)) begin
				b = bonds_pending.pop_front();
				ref_dx <= b.rx;
				ref_dy <= b.ry;
				ref_dz <= b.rz;
				cur_dx <= b.cx;
				cur_dy <= b.cy;
				cur_dz <= b.cz;
				modulus_first <= b.mod_i;
				modulus_second <= b.mod_j;
				limit_first <= b.lim_i;
				limit_second <= b.lim_j;
				in_valid <= 1'b1;
			end else
				in_valid <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	always @(posedge clk or negedge arst_n) begin
		force_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (forces_due.size() == 0)
					report("unexpected beat", force_x, 64'd0);
				else begin
					e = forces_due.pop_front();
					if (force_x !== e.fx) report("force_x", force_x, e.fx);
					if (force_y !== e.fy) report("force_y", force_y, e.fy);
					if (force_z !== e.fz) report("force_z", force_z, e.fz);
					if (bond_broken !== e.broken)
						report("bond_broken", 64'(bond_broken), 64'(e.broken));
				end
			end
			out_stall <= !steady && ($urandom_range(99) < 35);
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
				|| (bonds_pending.size() == 0 && forces_due.size() == 0 && !cfg_valid
				&& !in_valid))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	// register write, only issued with the pipeline drained
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			pbf_pkg::REG_HORIZON: horizon_q = value[30:0];
			pbf_pkg::REG_SPACING: spacing_q = value[30:0];
			pbf_pkg::REG_MODE:    mode_q = value[1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (bonds_pending.size() > 0 || forces_due.size() > 0 || in_valid)
			@(posedge clk);
	endtask

	task automatic phase(logic [31:0] h, logic [31:0] dx, logic [1:0] mode, int count,
			int span);
		write_reg(pbf_pkg::REG_HORIZON, h);
		write_reg(pbf_pkg::REG_SPACING, dx);
		write_reg(pbf_pkg::REG_MODE, mode);
		for (int i = 0; i < count; i++)
			add_bond(mixed_bond(span));
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed beats on the reset registers
		add_bond(bond_of(0, 0, 0, 1 << 20, 0, 0, 1000, 1000, 0, 0));
		add_bond(bond_of(1 << 20, 0, 0, 0, 0, 0, 1000, 1000, 1 << 28, 0));
		add_bond(bond_of(1 << 20, 0, 0, 1 << 21, 0, 0, 1000, 1000, 0, 0));
		add_bond(bond_of(1 << 20, 0, 0, (1 << 20) + 1024, 0, 0,
			1000, 1000, '1, '1));
		add_bond(bond_of(0, 1 << 21, 0, 0, -(1 << 21) - 4096, 0,
			'1, '1, '1, '1));
		add_bond(bond_of(0, 0, -(1 << 20), 0, 0, -(1 << 20) + 2048,
			500, 700, 1 << 26, 1 << 26));
		add_bond(bond_of(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '1, '1, '1, '1));
		add_bond(bond_of(32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 0, 0,
			'1, '1, '1, 32'hFFFF_FFFE));
		add_bond(bond_of(1, 0, 0, 0, 0, 1, '1, '1, 0, 0));
		add_bond(bond_of(1, 1, 1, 1, 1, 1, '1, '1, 1, 1));
		// past the horizon, inside the ramp, and on the inner edge of it
		add_bond(bond_of(4 << 20, 0, 0, (4 << 20) + 40000, 0, 0,
			'1, '1, '1, '1));
		add_bond(bond_of(3 << 20, 0, 0, (3 << 20) + 4000, 0, 0,
			5000, 5000, '1, 0));
		add_bond(bond_of((5 << 19), 0, 0, (5 << 19) - 300, 0, 0,
			5000, 5000, 0, 0));
		add_bond(bond_of(-(1 << 20), 1 << 20, -(1 << 20),
			-(1 << 20) - 5000, (1 << 20) + 5000, -(1 << 20) - 5000, 0, 0, '1, '1));
		add_bond(bond_of(-(1 << 20), 1 << 20, -(1 << 20),
			-(1 << 20) - 5000, (1 << 20) + 5000, -(1 << 20) - 5000, 9, 0, '1, '1));
		for (int i = 0; i < 150; i++)
			add_bond(mixed_bond(3 << 20));
		drain();

		phase(3 << 20, 1 << 20, pbf_pkg::MODE_STRESS, 300, 3 << 20);
		steady = 1'b1;
		phase((5 << 20) + 12345, 3 << 19, pbf_pkg::MODE_STRAIN, 300, 4 << 20);
		steady = 1'b0;
		// horizon at its top, spacing at its bottom
		phase(32'h7FFF_FFFF, 1, pbf_pkg::MODE_3D, 250, 1 << 30);
		// horizon at its bottom, spacing at its top
		phase(1, 32'h7FFF_FFFF, pbf_pkg::MODE_STRAIN, 250, 1 << 10);
		phase($urandom_range(32'h7FFF_FFFF, 1), $urandom_range(32'h00FF_FFFF, 1),
			pbf_pkg::MODE_STRESS, 200, 1 << 22);
		phase((2 << 20) + $urandom_range(1 << 20), 1 << 20, pbf_pkg::MODE_3D, 300, 2 << 20);

		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
